### rtl/sem_pkg.sv
`default_nettype none

package sem_pkg;

  localparam int PIXEL_BITS_DEF = 8;

  // Result width and cap are fixed by the output format.
  localparam int EDGE_BITS = 8;
  localparam logic [EDGE_BITS-1:0] EDGE_CAP = 8'd255;

  // Root unit input width: any sum of squares at or above 2**ROOT_IN_BITS caps.
  localparam int ROOT_IN_BITS = 16;
  localparam int ROOT_STEPS   = ROOT_IN_BITS / 2;

  // Row and channel positions in a column.
  localparam int ROW_TOP = 0;
  localparam int ROW_MID = 1;
  localparam int ROW_BOT = 2;
  localparam int CH_BLUE  = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_RED   = 2;

  // Window issue control from the column store to the lane pipeline.
  typedef struct packed {
    logic valid;
    logic done;
  } issue_t;

endpackage

`default_nettype wire

### rtl/sem_if.sv
`default_nettype none

interface sem_in_if import sem_pkg::*; #(
  parameter int PIXEL_BITS = PIXEL_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] top_blue;
  logic [PIXEL_BITS-1:0] top_green;
  logic [PIXEL_BITS-1:0] top_red;
  logic [PIXEL_BITS-1:0] mid_blue;
  logic [PIXEL_BITS-1:0] mid_green;
  logic [PIXEL_BITS-1:0] mid_red;
  logic [PIXEL_BITS-1:0] bottom_blue;
  logic [PIXEL_BITS-1:0] bottom_green;
  logic [PIXEL_BITS-1:0] bottom_red;
  logic                  row_end;

  modport source (
    output valid, top_blue, top_green, top_red, mid_blue, mid_green, mid_red,
           bottom_blue, bottom_green, bottom_red, row_end,
    input  ready
  );
  modport sink (
    input  valid, top_blue, top_green, top_red, mid_blue, mid_green, mid_red,
           bottom_blue, bottom_green, bottom_red, row_end,
    output ready
  );
endinterface

interface sem_out_if import sem_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [EDGE_BITS-1:0] edge_blue;
  logic [EDGE_BITS-1:0] edge_green;
  logic [EDGE_BITS-1:0] edge_red;
  logic                 row_done;

  modport source (
    output valid, edge_blue, edge_green, edge_red, row_done,
    input  ready
  );
  modport sink (
    input  valid, edge_blue, edge_green, edge_red, row_done,
    output ready
  );
endinterface

`default_nettype wire

### rtl/sem_lane.sv
`default_nettype none

// One color channel: gradients, squares, sum/clip, then rounded root in two halves.
module sem_lane import sem_pkg::*; #(
  parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic [2:0][PIXEL_BITS-1:0] left_px,
  input  logic [2:0][PIXEL_BITS-1:0] centre_px,
  input  logic [2:0][PIXEL_BITS-1:0] right_px,
  output logic [EDGE_BITS-1:0]       edge_mag
);

  localparam int MAG_W  = PIXEL_BITS + 2;
  localparam int GRAD_W = MAG_W + 1;
  localparam int SQ_W   = 2 * MAG_W;
  localparam int TOT_W  = (SQ_W + 1 > ROOT_IN_BITS + 1) ? SQ_W + 1 : ROOT_IN_BITS + 1;
  localparam int RW     = ROOT_IN_BITS + 1;
  localparam int HALF_STEPS = ROOT_STEPS / 2;

  function automatic logic [MAG_W-1:0] tap_sum(input logic [PIXEL_BITS-1:0] a,
                                                input logic [PIXEL_BITS-1:0] b,
                                                input logic [PIXEL_BITS-1:0] c);
    tap_sum = MAG_W'(a) + (MAG_W'(b) << 1) + MAG_W'(c);
  endfunction

  logic [GRAD_W-1:0] gx, gy;
  logic [MAG_W-1:0]  ax, ay;
  logic [MAG_W-1:0]  ax_r, ay_r;
  logic [SQ_W-1:0]   sq_x_r, sq_y_r;
  logic [TOT_W-1:0]  tot;
  logic              over_r;
  logic [ROOT_IN_BITS-1:0] root_in_r;
  logic [RW-1:0]     rem_a, res_a, bit_a;
  logic [RW-1:0]     rem_r, res_r;
  logic              over_root_r;
  logic [RW-1:0]     rem, res, bit_v;
  logic              round_up;

  always_comb begin
    gx = {1'b0, tap_sum(right_px[ROW_TOP], right_px[ROW_MID], right_px[ROW_BOT])}
       - {1'b0, tap_sum(left_px[ROW_TOP], left_px[ROW_MID], left_px[ROW_BOT])};
    gy = {1'b0, tap_sum(left_px[ROW_BOT], centre_px[ROW_BOT], right_px[ROW_BOT])}
       - {1'b0, tap_sum(left_px[ROW_TOP], centre_px[ROW_TOP], right_px[ROW_TOP])};
    ax = gx[GRAD_W-1] ? MAG_W'(-gx) : gx[MAG_W-1:0];
    ay = gy[GRAD_W-1] ? MAG_W'(-gy) : gy[MAG_W-1:0];
  end

  assign tot = TOT_W'(sq_x_r) + TOT_W'(sq_y_r);

  // Digit-by-digit root, two bits of input per step: upper half of the steps.
  always_comb begin
    rem_a = RW'(root_in_r);
    res_a = '0;
    bit_a = RW'(1) << (ROOT_IN_BITS - 2);
    for (int i = 0; i < HALF_STEPS; i++) begin
      if (rem_a >= res_a + bit_a) begin
        rem_a = rem_a - (res_a + bit_a);
        res_a = (res_a >> 1) + bit_a;
      end else begin
        res_a = res_a >> 1;
      end
      bit_a = bit_a >> 2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax_r        <= ax;
      ay_r        <= ay;
      sq_x_r      <= SQ_W'(ax_r) * SQ_W'(ax_r);
      sq_y_r      <= SQ_W'(ay_r) * SQ_W'(ay_r);
      over_r      <= |tot[TOT_W-1:ROOT_IN_BITS];
      root_in_r   <= tot[ROOT_IN_BITS-1:0];
      rem_r       <= rem_a;
      res_r       <= res_a;
      over_root_r <= over_r;
    end
  end

  // Lower half of the steps; rem ends as s - res^2.
  always_comb begin
    rem   = rem_r;
    res   = res_r;
    bit_v = RW'(1) << (ROOT_IN_BITS - 2 - 2 * HALF_STEPS);
    for (int i = HALF_STEPS; i < ROOT_STEPS; i++) begin
      if (rem >= res + bit_v) begin
        rem = rem - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v = bit_v >> 2;
    end
    round_up = rem > res;
    if (over_root_r) begin
      edge_mag = EDGE_CAP;
    end else if (round_up && res[EDGE_BITS-1:0] != EDGE_CAP) begin
      edge_mag = res[EDGE_BITS-1:0] + EDGE_BITS'(1);
    end else begin
      edge_mag = res[EDGE_BITS-1:0];
    end
  end

endmodule

`default_nettype wire

### rtl/sem_window.sv
`default_nettype none

// Column store: left/centre columns, issue of one window per result.
module sem_window import sem_pkg::*; #(
  parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  logic                            in_valid,
  input  logic [2:0][2:0][PIXEL_BITS-1:0] in_col,
  input  logic                            in_row_end,
  output logic                            in_ready,
  output issue_t                          issue,
  output logic [2:0][2:0][PIXEL_BITS-1:0] left_col,
  output logic [2:0][2:0][PIXEL_BITS-1:0] centre_col,
  output logic [2:0][2:0][PIXEL_BITS-1:0] right_col
);

  logic [2:0][2:0][PIXEL_BITS-1:0] left_r, centre_r;
  logic held_r, flush_r;
  logic acc;

  assign in_ready    = en && !flush_r;
  assign acc         = in_valid && in_ready;
  assign issue.valid = (acc && held_r) || (en && flush_r);
  assign issue.done  = flush_r;
  assign left_col    = left_r;
  assign centre_col  = centre_r;
  assign right_col   = flush_r ? '0 : in_col;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r   <= '0;
      centre_r <= '0;
      held_r   <= 1'b0;
      flush_r  <= 1'b0;
    end else if (en && flush_r) begin
      // row finished: back to an empty window
      left_r   <= '0;
      centre_r <= '0;
      held_r   <= 1'b0;
      flush_r  <= 1'b0;
    end else if (acc) begin
      left_r   <= held_r ? centre_r : '0;
      centre_r <= in_col;
      held_r   <= 1'b1;
      flush_r  <= in_row_end;
    end
  end

endmodule

`default_nettype wire

### rtl/sobel_edge_magnitude_rgb.sv
`default_nettype none

// Channel  Dir  Word
// in_ch    in   one image column: top/mid/bottom RGB pixels, row_end
// out_ch   out  one edge pixel: edge_blue/green/red, row_done
//
// One column accepted per cycle while the output is not stalled; a column with
// row_end holds the input while the flushed last pixel of the row is issued.
// Registered stages from issue (accept edge, or the flush cycle) to out_ch.valid:
// gradients, squares, sum/clip, upper root half; lower root half feeds the output reg.
// rst_n (synchronous) empties the column store and all pipeline valids.
// A stalled output freezes the whole lane pipeline and the input.
module sobel_edge_magnitude_rgb import sem_pkg::*; #(
  parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  sem_in_if.sink    in_ch,
  sem_out_if.source out_ch
);

  localparam int NUM_CH = 3;

  logic [2:0][2:0][PIXEL_BITS-1:0] in_col;
  logic [2:0][2:0][PIXEL_BITS-1:0] left_col, centre_col, right_col;
  issue_t issue;
  logic en;
  logic in_ready;

  // pipeline valids and row_done tags, one per lane stage
  logic v1_r, v2_r, v3_r, v4_r, d1_r, d2_r, d3_r, d4_r;
  logic out_valid_r, out_done_r;
  logic [NUM_CH-1:0][EDGE_BITS-1:0] lane_edge;
  logic [NUM_CH-1:0][EDGE_BITS-1:0] edge_r;

  // whole pipe advances whenever the output register is free or drains
  assign en = !out_valid_r || out_ch.ready;

  assign in_col[ROW_TOP][CH_BLUE]  = in_ch.top_blue;
  assign in_col[ROW_TOP][CH_GREEN] = in_ch.top_green;
  assign in_col[ROW_TOP][CH_RED]   = in_ch.top_red;
  assign in_col[ROW_MID][CH_BLUE]  = in_ch.mid_blue;
  assign in_col[ROW_MID][CH_GREEN] = in_ch.mid_green;
  assign in_col[ROW_MID][CH_RED]   = in_ch.mid_red;
  assign in_col[ROW_BOT][CH_BLUE]  = in_ch.bottom_blue;
  assign in_col[ROW_BOT][CH_GREEN] = in_ch.bottom_green;
  assign in_col[ROW_BOT][CH_RED]   = in_ch.bottom_red;

  sem_window #(.PIXEL_BITS(PIXEL_BITS)) u_window (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_valid   (in_ch.valid),
    .in_col     (in_col),
    .in_row_end (in_ch.row_end),
    .in_ready   (in_ready),
    .issue      (issue),
    .left_col   (left_col),
    .centre_col (centre_col),
    .right_col  (right_col)
  );

  assign in_ch.ready = in_ready;

  // one lane per color channel, all fed the same window
  for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_lane
    logic [2:0][PIXEL_BITS-1:0] l_px, c_px, r_px;
    for (genvar row = 0; row < 3; row++) begin : g_row
      assign l_px[row] = left_col[row][ch];
      assign c_px[row] = centre_col[row][ch];
      assign r_px[row] = right_col[row][ch];
    end
    sem_lane #(.PIXEL_BITS(PIXEL_BITS)) u_lane (
      .clk       (clk),
      .en        (en),
      .left_px   (l_px),
      .centre_px (c_px),
      .right_px  (r_px),
      .edge_mag  (lane_edge[ch])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r        <= issue.valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      out_valid_r <= v4_r;
    end
  end

  // merge: lane results and row tag into one output word
  always_ff @(posedge clk) begin
    if (en) begin
      d1_r       <= issue.done;
      d2_r       <= d1_r;
      d3_r       <= d2_r;
      d4_r       <= d3_r;
      out_done_r <= d4_r;
      edge_r     <= lane_edge;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.edge_blue  = edge_r[CH_BLUE];
  assign out_ch.edge_green = edge_r[CH_GREEN];
  assign out_ch.edge_red   = edge_r[CH_RED];
  assign out_ch.row_done   = out_done_r;

  // a row-end column must block the next column while its flush is pending
  a_flush_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ready && in_ch.row_end) |=> !in_ready)
    else $error("input taken while row flush pending");

  // the flush window never coincides with an input accept
  a_flush_alone: assert property (@(posedge clk) disable iff (!rst_n)
    (issue.valid && issue.done) |-> !(in_ch.valid && in_ready))
    else $error("input accepted during flush issue");

  // nothing enters the lanes while they are frozen
  a_issue_en: assert property (@(posedge clk) disable iff (!rst_n)
    issue.valid |-> en)
    else $error("window issued into a stalled pipeline");

endmodule

`default_nettype wire
